FILE: sv/assert_macros.svh
// Assertion macros shared by the FLIC chunk decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("flicpcd assertion failed");
`define FPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("flicpcd assertion failed");
`else
`define FPC_ASSERT(lbl, prop)
`define FPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/flicpcd_pkg.sv
// Types, codes and helpers of the FLIC pixel chunk decoder.
package flicpcd_pkg;

	localparam int unsigned MAX_PIXELS_DEF = 4194304;
	localparam logic [22:0] SAT23 = 23'h7FFFFF;
	localparam logic [11:0] WIDTH_RST = 12'd320;
	localparam logic [11:0] HEIGHT_RST = 12'd200;
	localparam logic [23:0] AREA_RST = 24'd64000;

	typedef enum logic [1:0] {
		MODE_COPY = 2'd0,
		MODE_BRUN = 2'd1,
		MODE_LC   = 2'd2,
		MODE_SS2  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_MODE   = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_Y_HI   = 4'd1,
		PH_N_LO   = 4'd2,
		PH_N_HI   = 4'd3,
		PH_LINE   = 4'd4,
		PH_PW_LO  = 4'd5,
		PH_PW_HI  = 4'd6,
		PH_SKIP   = 4'd7,
		PH_COUNT  = 4'd8,
		PH_REP    = 4'd9,
		PH_LIT    = 4'd10,
		PH_REP_LO = 4'd11,
		PH_REP_HI = 4'd12,
		PH_COPY   = 4'd13,
		PH_DONE   = 4'd14
	} phase_t;

	typedef struct packed {
		mode_t       mode;
		logic [11:0] width;
		logic [11:0] height;
		logic [23:0] area;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [21:0] write_address;
		logic [8:0]  run_length;
		logic [7:0]  first_pixel;
		logic [7:0]  second_pixel;
		logic        pair_pattern;
		logic        out_of_range;
		logic        chunk_done;
	} res_t;

	function automatic logic [22:0] sat23(input logic [29:0] v);
		logic [22:0] r;
		r = (v > 30'(SAT23)) ? SAT23 : v[22:0];
		return r;
	endfunction

endpackage

FILE: sv/flic_pixel_chunk_decoder.sv
// Top level of the FLIC 8-bit pixel chunk decoder: ports, registers, handshake.
//
// Input stream: one payload byte per transfer on s_axis_tdata, with
// s_axis_tuser[0] high on the first byte of a chunk to restart the parser.
// Output stream: at most one framebuffer write run per input byte; runs
// that end past the frame are still sent with the out-of-range flag set,
// and tlast marks the write that ends the chunk's final line.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write chunk kind (0),
// frame width (1) and frame height (2); write only while the block is idle.
// Data path: a byte is captured in the input register, stepped through the
// combinational parser, and its run is registered in the result register
// on the same edge that updates the parser state.
// Throughput: one byte per cycle unless stalled as below.
// When the receiver stalls, the result register holds its run; the input
// register keeps taking bytes that produce no run and stalls only when a
// byte with a run meets a full result register.
// Reset clears the parser to expect a chunk header and restores the
// register defaults (copy, 320 by 200); no output is valid after reset.
`include "assert_macros.svh"

module flic_pixel_chunk_decoder #(
	parameter int unsigned MAX_PIXELS = flicpcd_pkg::MAX_PIXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] chunk_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [21:0] write_address, [30:22] run_length, [38:31] first_pixel,
	// [46:39] second_pixel, [47] zero
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [0] pair_pattern, [1] out_of_range
	output logic        m_axis_tlast,  // chunk_done
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata
);

	flicpcd_pkg::mode_t mode_q;
	logic [11:0] width_q, height_q;
	logic [23:0] area_q;
	flicpcd_pkg::cfg_t cfg;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_start_s1;
	logic       advance;
	logic       out_valid_q;
	flicpcd_pkg::res_t res, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= flicpcd_pkg::MODE_COPY;
			width_q  <= flicpcd_pkg::WIDTH_RST;
			height_q <= flicpcd_pkg::HEIGHT_RST;
			area_q   <= flicpcd_pkg::AREA_RST;
		end else if (cfg_wr_en) begin
			unique case (flicpcd_pkg::cfg_idx_t'(cfg_index))
				flicpcd_pkg::CFG_MODE: mode_q <= flicpcd_pkg::mode_t'(cfg_wdata[1:0]);
				flicpcd_pkg::CFG_WIDTH: begin
					width_q <= cfg_wdata;
					area_q  <= 24'(cfg_wdata) * 24'(height_q);
				end
				flicpcd_pkg::CFG_HEIGHT: begin
					height_q <= cfg_wdata;
					area_q   <= 24'(width_q) * 24'(cfg_wdata);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.mode   = mode_q;
		cfg.width  = width_q;
		cfg.height = height_q;
		cfg.area   = area_q;
	end

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready || !res.valid);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1  <= s_axis_tdata;
			in_start_s1 <= s_axis_tuser[0];
		end
	end

	flicpcd_parser #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.data_byte   (in_byte_s1),
		.chunk_start (in_start_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.second_pixel, out_q.first_pixel,
		out_q.run_length, out_q.write_address};
	assign m_axis_tuser  = {out_q.out_of_range, out_q.pair_pattern};
	assign m_axis_tlast  = out_q.chunk_done;

	`FPC_ASSERT(a_pair_even, (out_valid_q && out_q.pair_pattern) |-> !out_q.run_length[0])
	`FPC_ASSERT(a_out_from_step, $rose(out_valid_q) |-> $past(advance))
	`FPC_ASSERT_NEXT(a_s1_held, in_valid_s1 && !advance, in_valid_s1)

endmodule

FILE: sv/flicpcd_parser.sv
// Chunk parser: parse state registers and the one-byte step logic.
`include "assert_macros.svh"

module flicpcd_parser #(
	parameter int unsigned MAX_PIXELS = flicpcd_pkg::MAX_PIXELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_byte,
	input  logic                chunk_start,
	input  flicpcd_pkg::cfg_t   cfg,
	output flicpcd_pkg::res_t   res
);

	localparam logic [23:0] PIX_LIMIT = 24'(MAX_PIXELS);

	flicpcd_pkg::phase_t phase_q, cur_phase, n_phase, end_phase, pkt_phase;
	logic [15:0] lines_q, cur_lines, n_lines;
	logic [15:0] packets_q, cur_packets, n_packets;
	logic [8:0]  bytes_q, cur_bytes, n_bytes;
	logic [22:0] pp_q, cur_pp, n_pp;
	logic [22:0] lb_q, cur_lb, n_lb;
	logic [7:0]  hold_q, cur_hold, n_hold;

	logic [9:0]  amt;
	logic [22:0] pp_step, chk_pp, lb_next_line, lb_last_px, lb_mul, lb_skip, total;
	logic [23:0] pp_inc, chk_diff, lim, end_addr;
	logic        chk_over;
	logic [15:0] word, mul_a;
	logic [14:0] neg_word;
	logic [27:0] prod;

	logic        e_req, e_pair, e_force, fin, do_pkt, do_end, do_chk;
	logic [22:0] e_addr;
	logic [9:0]  e_len;
	logic [7:0]  e_a, e_b;

	assign cur_phase   = chunk_start ? flicpcd_pkg::PH_START : phase_q;
	assign cur_lines   = chunk_start ? '0 : lines_q;
	assign cur_packets = chunk_start ? '0 : packets_q;
	assign cur_bytes   = chunk_start ? '0 : bytes_q;
	assign cur_pp      = chunk_start ? '0 : pp_q;
	assign cur_lb      = chunk_start ? '0 : lb_q;
	assign cur_hold    = chunk_start ? '0 : hold_q;

	always_comb begin
		case (cur_phase)
			flicpcd_pkg::PH_SKIP:   amt = {2'b00, data_byte};
			flicpcd_pkg::PH_LIT:    amt = 10'd1;
			flicpcd_pkg::PH_REP:    amt = {1'b0, cur_bytes};
			flicpcd_pkg::PH_REP_HI: amt = {cur_bytes, 1'b0};
			default:                amt = '0;
		endcase
	end

	assign pp_step      = flicpcd_pkg::sat23(30'(cur_pp) + 30'(amt));
	assign lb_next_line = flicpcd_pkg::sat23(30'(cur_lb) + 30'(cfg.width));
	assign lb_last_px   = flicpcd_pkg::sat23(30'(cur_lb) + 30'(cfg.width) - 30'd1);

	assign word     = {data_byte, cur_hold};
	assign neg_word = 15'(17'h10000 - {1'b0, word});
	assign mul_a    = (cfg.mode == flicpcd_pkg::MODE_LC) ? word : {1'b0, neg_word};
	assign prod     = 28'(mul_a) * 28'(cfg.width);
	assign lb_mul   = flicpcd_pkg::sat23(30'(prod));
	assign lb_skip  = flicpcd_pkg::sat23(30'(cur_lb) + 30'(prod));

	assign chk_pp   = (cur_phase == flicpcd_pkg::PH_REP || cur_phase == flicpcd_pkg::PH_LIT)
		? pp_step : cur_pp;
	assign chk_diff = {1'b0, chk_pp} - {1'b0, cur_lb};
	assign chk_over = chk_diff[23] || (chk_diff[22:0] >= 23'(cfg.width));

	assign total  = (cfg.area > 24'(flicpcd_pkg::SAT23)) ? flicpcd_pkg::SAT23 : cfg.area[22:0];
	assign pp_inc = {1'b0, cur_pp} + 24'd1;

	always_comb begin
		n_phase   = cur_phase;
		n_lines   = cur_lines;
		n_packets = cur_packets;
		n_bytes   = cur_bytes;
		n_pp      = cur_pp;
		n_lb      = cur_lb;
		n_hold    = cur_hold;
		e_req     = 1'b0;
		e_addr    = cur_pp;
		e_len     = 10'd1;
		e_a       = data_byte;
		e_b       = '0;
		e_pair    = 1'b0;
		e_force   = 1'b0;
		fin       = 1'b0;
		do_pkt    = 1'b0;
		do_end    = 1'b0;
		do_chk    = 1'b0;
		pkt_phase = flicpcd_pkg::PH_LINE;
		end_phase = flicpcd_pkg::PH_LINE;
		if (cur_phase != flicpcd_pkg::PH_DONE) begin
			unique case (cfg.mode)
				flicpcd_pkg::MODE_COPY: begin
					if ((cur_phase != flicpcd_pkg::PH_START && cur_phase != flicpcd_pkg::PH_COPY)
						|| cur_pp >= total) begin
						n_phase = flicpcd_pkg::PH_DONE;
					end else begin
						e_req = 1'b1;
						n_pp = pp_inc[22:0];
						if (pp_inc >= {1'b0, total}) begin
							n_phase = flicpcd_pkg::PH_DONE;
							fin = 1'b1;
						end else begin
							n_phase = flicpcd_pkg::PH_COPY;
						end
					end
				end
				flicpcd_pkg::MODE_BRUN: begin
					unique case (cur_phase)
						flicpcd_pkg::PH_START: begin
							n_lines = 16'(cfg.height);
							if (cfg.height == '0) n_phase = flicpcd_pkg::PH_DONE;
							else do_chk = 1'b1;
						end
						flicpcd_pkg::PH_LINE: do_chk = 1'b1;
						flicpcd_pkg::PH_COUNT: begin
							if (data_byte[7]) begin
								n_bytes = 9'd256 - {1'b0, data_byte};
								n_phase = flicpcd_pkg::PH_LIT;
							end else begin
								n_bytes = {1'b0, data_byte};
								n_phase = flicpcd_pkg::PH_REP;
							end
						end
						flicpcd_pkg::PH_REP: begin
							e_req = 1'b1;
							e_len = {1'b0, cur_bytes};
							n_pp = pp_step;
							do_chk = 1'b1;
						end
						flicpcd_pkg::PH_LIT: begin
							e_req = 1'b1;
							n_pp = pp_step;
							if (cur_bytes <= 9'd1) begin
								n_bytes = '0;
								do_chk = 1'b1;
							end else begin
								n_bytes = cur_bytes - 9'd1;
							end
						end
						default: n_phase = flicpcd_pkg::PH_DONE;
					endcase
				end
				flicpcd_pkg::MODE_LC: begin
					pkt_phase = flicpcd_pkg::PH_LINE;
					unique case (cur_phase)
						flicpcd_pkg::PH_START: begin
							n_hold = data_byte;
							n_phase = flicpcd_pkg::PH_Y_HI;
						end
						flicpcd_pkg::PH_Y_HI: begin
							n_lb = lb_mul;
							n_pp = lb_mul;
							n_phase = flicpcd_pkg::PH_N_LO;
						end
						flicpcd_pkg::PH_N_LO: begin
							n_hold = data_byte;
							n_phase = flicpcd_pkg::PH_N_HI;
						end
						flicpcd_pkg::PH_N_HI: begin
							n_lines = word;
							n_phase = (word == '0) ? flicpcd_pkg::PH_DONE : flicpcd_pkg::PH_LINE;
						end
						flicpcd_pkg::PH_LINE: begin
							n_pp = cur_lb;
							n_packets = {8'd0, data_byte};
							if (data_byte == '0) begin
								do_end = 1'b1;
								end_phase = flicpcd_pkg::PH_LINE;
							end else begin
								n_phase = flicpcd_pkg::PH_SKIP;
							end
						end
						flicpcd_pkg::PH_COUNT: begin
							if (data_byte[7]) begin
								n_bytes = 9'd256 - {1'b0, data_byte};
								n_phase = flicpcd_pkg::PH_REP;
							end else if (data_byte == '0) begin
								do_pkt = 1'b1;
							end else begin
								n_bytes = {1'b0, data_byte};
								n_phase = flicpcd_pkg::PH_LIT;
							end
						end
						flicpcd_pkg::PH_REP: begin
							e_req = 1'b1;
							e_len = {1'b0, cur_bytes};
							n_pp = pp_step;
							do_pkt = 1'b1;
						end
						flicpcd_pkg::PH_SKIP: begin
							n_pp = pp_step;
							n_phase = flicpcd_pkg::PH_COUNT;
						end
						flicpcd_pkg::PH_LIT: begin
							e_req = 1'b1;
							n_pp = pp_step;
							if (cur_bytes <= 9'd1) begin
								n_bytes = '0;
								do_pkt = 1'b1;
							end else begin
								n_bytes = cur_bytes - 9'd1;
							end
						end
						default: n_phase = flicpcd_pkg::PH_DONE;
					endcase
				end
				flicpcd_pkg::MODE_SS2: begin
					pkt_phase = flicpcd_pkg::PH_PW_LO;
					unique case (cur_phase)
						flicpcd_pkg::PH_START: begin
							n_hold = data_byte;
							n_phase = flicpcd_pkg::PH_N_HI;
						end
						flicpcd_pkg::PH_N_HI: begin
							n_lines = word;
							n_phase = (word == '0) ? flicpcd_pkg::PH_DONE : flicpcd_pkg::PH_PW_LO;
						end
						flicpcd_pkg::PH_PW_LO: begin
							n_hold = data_byte;
							n_phase = flicpcd_pkg::PH_PW_HI;
						end
						flicpcd_pkg::PH_PW_HI: begin
							n_pp = cur_lb;
							if (data_byte[7] && data_byte[6]) begin
								n_lb = lb_skip;
								n_pp = lb_skip;
								n_phase = flicpcd_pkg::PH_PW_LO;
							end else if (data_byte[7]) begin
								e_req = 1'b1;
								e_a = cur_hold;
								if (cfg.width == '0) begin
									e_addr = cur_lb;
									e_force = 1'b1;
								end else begin
									e_addr = lb_last_px;
								end
								n_phase = flicpcd_pkg::PH_PW_LO;
							end else begin
								n_packets = word;
								if (word == '0) begin
									do_end = 1'b1;
									end_phase = flicpcd_pkg::PH_PW_LO;
								end else begin
									n_phase = flicpcd_pkg::PH_SKIP;
								end
							end
						end
						flicpcd_pkg::PH_COUNT: begin
							if (data_byte[7]) begin
								n_bytes = 9'd256 - {1'b0, data_byte};
								n_phase = flicpcd_pkg::PH_REP_LO;
							end else if (data_byte == '0) begin
								do_pkt = 1'b1;
							end else begin
								n_bytes = {data_byte, 1'b0};
								n_phase = flicpcd_pkg::PH_LIT;
							end
						end
						flicpcd_pkg::PH_REP_LO: begin
							n_hold = data_byte;
							n_phase = flicpcd_pkg::PH_REP_HI;
						end
						flicpcd_pkg::PH_REP_HI: begin
							e_req = 1'b1;
							e_len = {cur_bytes[8:0], 1'b0};
							e_b = cur_hold;
							e_pair = 1'b1;
							n_pp = pp_step;
							do_pkt = 1'b1;
						end
						flicpcd_pkg::PH_SKIP: begin
							n_pp = pp_step;
							n_phase = flicpcd_pkg::PH_COUNT;
						end
						flicpcd_pkg::PH_LIT: begin
							e_req = 1'b1;
							n_pp = pp_step;
							if (cur_bytes <= 9'd1) begin
								n_bytes = '0;
								do_pkt = 1'b1;
							end else begin
								n_bytes = cur_bytes - 9'd1;
							end
						end
						default: n_phase = flicpcd_pkg::PH_DONE;
					endcase
				end
			endcase
		end
		if (do_chk) begin
			if (chk_over) begin
				do_end = 1'b1;
				end_phase = flicpcd_pkg::PH_LINE;
			end else begin
				n_phase = flicpcd_pkg::PH_COUNT;
			end
		end
		if (do_pkt) begin
			if (n_packets <= 16'd1) begin
				n_packets = '0;
				do_end = 1'b1;
				end_phase = pkt_phase;
			end else begin
				n_packets = n_packets - 16'd1;
				n_phase = flicpcd_pkg::PH_SKIP;
			end
		end
		if (do_end) begin
			n_lb = lb_next_line;
			n_pp = lb_next_line;
			if (n_lines <= 16'd1) begin
				n_lines = '0;
				n_phase = flicpcd_pkg::PH_DONE;
				fin = 1'b1;
			end else begin
				n_lines = n_lines - 16'd1;
				n_phase = end_phase;
			end
		end
	end

	// frame limit and overrun check for the emitted run
	assign lim      = (cfg.area < PIX_LIMIT) ? cfg.area : PIX_LIMIT;
	assign end_addr = {1'b0, e_addr} + 24'(e_len);

	always_comb begin
		res.valid         = e_req && (e_len != '0);
		res.write_address = e_addr[21:0];
		res.run_length    = e_len[8:0];
		res.first_pixel   = e_a;
		res.second_pixel  = e_b;
		res.pair_pattern  = e_pair;
		res.out_of_range  = e_force || (end_addr > lim);
		res.chunk_done    = fin && e_req && (e_len != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= flicpcd_pkg::PH_START;
			lines_q   <= '0;
			packets_q <= '0;
			bytes_q   <= '0;
			pp_q      <= '0;
			lb_q      <= '0;
			hold_q    <= '0;
		end else if (step_en) begin
			phase_q   <= n_phase;
			lines_q   <= n_lines;
			packets_q <= n_packets;
			bytes_q   <= n_bytes;
			pp_q      <= n_pp;
			lb_q      <= n_lb;
			hold_q    <= n_hold;
		end
	end

	`FPC_ASSERT_NEXT(a_done_ends_chunk, step_en && res.valid && res.chunk_done,
		phase_q == flicpcd_pkg::PH_DONE)
	`FPC_ASSERT(a_idle_after_done,
		(step_en && !chunk_start && phase_q == flicpcd_pkg::PH_DONE) |-> !res.valid)
	`FPC_ASSERT(a_run_nonzero, res.valid |-> (res.run_length != 9'd0))

endmodule
